/* hw/rtl/pmac_pkg.sv */
// ----------------------------------------------------------------------------
// pmac_pkg
// Shared types, constants and control structs for the pulse moving average
// and clamp block.
// ----------------------------------------------------------------------------
package pmac_pkg;

  // field and storage widths
  localparam int PW_W       = 15;
  localparam int LEN_W      = 5;
  localparam int MAX_WINDOW = 16;
  localparam int WIN_AW     = $clog2(MAX_WINDOW);
  localparam int SUM_W      = 19;
  localparam int CNT_W      = $clog2(SUM_W);
  localparam int CFG_IDX_W  = 2;

  // constants
  localparam logic [PW_W-1:0]  PULSE_TIMEOUT = 15'd25000;
  localparam logic [PW_W-1:0]  LOW_RST       = 15'd1000;
  localparam logic [PW_W-1:0]  HIGH_RST      = 15'd2000;
  localparam logic [LEN_W-1:0] LEN_RST       = 5'd10;
  localparam logic [LEN_W-1:0] LEN_MAX       = LEN_W'(MAX_WINDOW);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_LIMIT     = 2'd0,
    CFG_HIGH_LIMIT    = 2'd1,
    CFG_WINDOW_LENGTH = 2'd2
  } cfg_idx_e;

  // input beat
  typedef struct packed {
    logic            func;
    logic [PW_W-1:0] pulse_width;
  } in_t;

  // output beat
  typedef struct packed {
    logic [PW_W-1:0] filtered_value;
    logic [PW_W-1:0] range_low;
    logic [PW_W-1:0] range_high;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic capture;   // take the input beat
    logic update;    // window write, sum update, divider load
    logic div_step;  // one quotient bit
    logic load_out;  // clamp and fill the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic calibrate; // func of the beat on the input
  } sts_t;

endpackage

/* hw/rtl/pmac_ctrl.sv */
// ----------------------------------------------------------------------------
// pmac_ctrl
// Sequencer: accepts a beat, steps the window update and the serial
// divider, and hands the result to the output register.
// ----------------------------------------------------------------------------
module pmac_ctrl import pmac_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output logic cfg_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIVIDE,
    ST_DONE
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  // output register may be refilled when empty or drained this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  // commands
  always_comb begin
    cmd_o          = '0;
    cmd_o.capture  = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.update   = (state_q == ST_UPDATE);
    cmd_o.div_step = (state_q == ST_DIVIDE);
    cmd_o.load_out = (state_q == ST_DONE) && out_free;
  end

  // next state
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = sts_i.calibrate ? ST_DONE : ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cnt_d   = '0;
        state_d = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(SUM_W - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  // an offered input beat takes the edge, so a write never lands with one
  assign cfg_ready_o = (state_q == ST_IDLE) && !in_valid_i;
  assign out_valid_o = out_valid_q;

endmodule

/* hw/rtl/pmac_datapath.sv */
// ----------------------------------------------------------------------------
// pmac_datapath
// Sample window, running sum, restoring divider, limit tracking,
// configuration registers and the output register.
// ----------------------------------------------------------------------------
module pmac_datapath import pmac_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  in_t                  in_data_i,
  output out_t                 out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [PW_W-1:0]      cfg_data_i,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o
);

  // configuration and tracked state
  logic [PW_W-1:0]  low_lim_q, high_lim_q;
  logic [LEN_W-1:0] len_q;
  logic [PW_W-1:0]  trk_low_q, trk_high_q;
  logic [PW_W-1:0]  last_q;

  // window
  logic [PW_W-1:0]       win_q [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] win_vld_q;
  logic [SUM_W-1:0]      sum_q;
  logic [WIN_AW-1:0]     pos_q;

  // item and divider
  logic             func_q;
  logic [PW_W-1:0]  pw_q;
  logic [SUM_W-1:0] quo_q;
  logic [LEN_W-1:0] rem_q;
  out_t             out_q;

  logic [PW_W-1:0]   pw_in;
  logic              win_clr;
  logic [WIN_AW-1:0] pos_eff;
  logic [LEN_W-1:0]  pos_inc;
  logic [WIN_AW-1:0] pos_nxt;
  logic [PW_W-1:0]   old_val;
  logic [SUM_W-1:0]  sum_new;
  logic [LEN_W:0]    rem_sh;
  logic              rem_ge;
  logic [PW_W-1:0]   clamped;
  logic [LEN_W-1:0]  len_wr;

  assign sts_o.calibrate = in_data_i.func;

  // over-range pulse counts as a timeout
  assign pw_in = (in_data_i.pulse_width > PULSE_TIMEOUT) ? '0 : in_data_i.pulse_width;

  // configuration decode and window clear
  always_comb begin
    win_clr = 1'b0;
    len_wr  = (cfg_data_i[LEN_W-1:0] > LEN_MAX) ? LEN_MAX : cfg_data_i[LEN_W-1:0];
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_LOW_LIMIT:     win_clr = (cfg_data_i < high_lim_q);
        CFG_HIGH_LIMIT:    win_clr = (low_lim_q < cfg_data_i);
        CFG_WINDOW_LENGTH: win_clr = (cfg_data_i[LEN_W-1:0] != '0);
        default:           win_clr = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_lim_q  <= LOW_RST;
      high_lim_q <= HIGH_RST;
      len_q      <= LEN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_LOW_LIMIT:  low_lim_q  <= cfg_data_i;
        CFG_HIGH_LIMIT: high_lim_q <= cfg_data_i;
        CFG_WINDOW_LENGTH: begin
          if (win_clr) begin
            len_q <= len_wr;
          end
        end
        default: ;
      endcase
    end
  end

  // tracked limits: reload on a valid limit write, widen on calibrate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trk_low_q  <= LOW_RST;
      trk_high_q <= HIGH_RST;
    end else if (win_clr && cfg_idx_e'(cfg_index_i) == CFG_LOW_LIMIT) begin
      trk_low_q  <= cfg_data_i;
      trk_high_q <= high_lim_q;
    end else if (win_clr && cfg_idx_e'(cfg_index_i) == CFG_HIGH_LIMIT) begin
      trk_low_q  <= low_lim_q;
      trk_high_q <= cfg_data_i;
    end else if (cmd_i.capture && in_data_i.func) begin
      if (pw_in < trk_low_q) begin
        trk_low_q <= pw_in;
      end
      if (pw_in > trk_high_q) begin
        trk_high_q <= pw_in;
      end
    end
  end

  // window slot, evicted value and new sum
  always_comb begin
    pos_eff = ({1'b0, pos_q} >= len_q) ? '0 : pos_q;
    pos_inc = {1'b0, pos_eff} + 1'b1;
    pos_nxt = (pos_inc >= len_q) ? '0 : pos_inc[WIN_AW-1:0];
    old_val = win_vld_q[pos_eff] ? win_q[pos_eff] : '0;
    sum_new = sum_q - SUM_W'(old_val) + SUM_W'(pw_q);
  end

  // window control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_vld_q <= '0;
      sum_q     <= '0;
      pos_q     <= '0;
    end else if (win_clr) begin
      win_vld_q <= '0;
      sum_q     <= '0;
      pos_q     <= '0;
    end else if (cmd_i.update) begin
      win_vld_q[pos_eff] <= 1'b1;
      sum_q              <= sum_new;
      pos_q              <= pos_nxt;
    end
  end

  // window entries
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      win_q[pos_eff] <= pw_q;
    end
  end

  // restoring divider step
  always_comb begin
    rem_sh = {rem_q, quo_q[SUM_W-1]};
    rem_ge = (rem_sh >= {1'b0, len_q});
  end

  // item capture and divider
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= in_data_i.func;
      pw_q   <= pw_in;
    end
    if (cmd_i.update) begin
      quo_q <= sum_new;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[SUM_W-2:0], rem_ge};
      rem_q <= rem_ge ? LEN_W'(rem_sh - {1'b0, len_q}) : rem_sh[LEN_W-1:0];
    end
  end

  // clamp to the tracked limits
  always_comb begin
    if (quo_q < SUM_W'(trk_low_q)) begin
      clamped = trk_low_q;
    end else if (quo_q > SUM_W'(trk_high_q)) begin
      clamped = trk_high_q;
    end else begin
      clamped = quo_q[PW_W-1:0];
    end
  end

  // last filtered value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else if (cmd_i.load_out && !func_q) begin
      last_q <= clamped;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.filtered_value <= func_q ? last_q : clamped;
      out_q.range_low      <= trk_low_q;
      out_q.range_high     <= trk_high_q;
    end
  end

  assign out_data_o = out_q;

endmodule

/* hw/rtl/pulse_moving_average_clamp.sv */
// ----------------------------------------------------------------------------
// pulse_moving_average_clamp
// Moving average of pulse widths over a configurable window, clamped to
// tracked limits that calibrate beats widen.
// ----------------------------------------------------------------------------
// A filter beat steps from the accepting state through a window and running
// sum update, the bit-serial divider (one quotient bit per cycle over the
// 19-bit sum), and a final state that clamps and loads the output register;
// its result is valid once that load is registered. A calibrate beat goes
// from the accepting state straight to the final load state. The next beat
// is accepted once the result sits in the output register, even while that
// result is still stalled; a result waits for the output register to drain
// before it is loaded, which holds the block in the final state. Writes to
// the configuration are taken whenever no beat is in progress and none is
// offered on the input.
module pulse_moving_average_clamp import pmac_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_t                  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_t                 out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [PW_W-1:0]      cfg_data_i
);

  cmd_t cmd;
  sts_t sts;
  logic cfg_we;

  assign cfg_we = cfg_valid_i && cfg_ready_o;

  // sequencer
  pmac_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cfg_ready_o (cfg_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath
  pmac_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

/* hw/rtl/pmac_checker.sv */
// ----------------------------------------------------------------------------
// pmac_checker
// Port-level checks for the pulse moving average and clamp block, bound to
// the top level.
// ----------------------------------------------------------------------------
module pmac_checker import pmac_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input out_t                 out_data_o,
  input logic                 cfg_ready_o
);

  // an accepted beat holds off the next one
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after an accepted beat");

  // no configuration write while a beat is in progress
  a_cfg_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> !cfg_ready_o)
    else $error("configuration ready while a beat is in progress");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result beat changed");

  // tracked limits stay ordered
  a_limits_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.range_low <= out_data_o.range_high))
    else $error("result limits out of order");

endmodule

bind pulse_moving_average_clamp pmac_checker u_pmac_checker (.*);
